// ----- sv/hbar_pkg.sv -----
// hbar_pkg: shared constants, codes and control structs for the associative recall block
// used by hbar_ctrl, hbar_dp and hebbian_associative_recall; no dependencies
`default_nettype none

package hbar_pkg;

  localparam int NEURONS_DEF     = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int PAT_BITS    = 16;
  localparam int CNT_BITS    = 7;
  localparam int SWEEP_BITS  = 8;
  localparam int STATUS_BITS = 2;
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 32;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CNT_BITS-1:0] COUNT_MAX = 7'd127;

  localparam logic CMD_TRAIN  = 1'b0;
  localparam logic CMD_RECALL = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_DONE        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_REJECTED    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NO_CONVERGE = 2'd2;

  localparam logic [1:0] REG_LIMIT_ENABLE = 2'd0;
  localparam logic [1:0] REG_MAX_SAMPLES  = 2'd1;
  localparam logic [1:0] REG_MAX_SWEEPS   = 2'd2;

  localparam logic                  LIMIT_ENABLE_RST = 1'b0;
  localparam logic [CNT_BITS-1:0]   MAX_SAMPLES_RST  = 7'd2;
  localparam logic [SWEEP_BITS-1:0] MAX_SWEEPS_RST   = 8'd16;

  typedef struct packed {
    logic capture;
    logic train;
    logic rd_en;
    logic upd_en;
    logic count_inc;
    logic sweep_start;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic changed;
  } dp_stat_t;

  typedef struct packed {
    logic                   load;
    logic                   recall;
    logic [STATUS_BITS-1:0] status;
    logic [SWEEP_BITS-1:0]  sweeps;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/hebbian_associative_recall.sv -----
// hebbian_associative_recall: binary associative memory with hebbian training and recall
// top level; holds config registers and the result register
// depends on hbar_pkg, hbar_ctrl and hbar_dp
//
// usage
//   in channel: in_tuser selects train (0) or recall (1), in_tdata carries the pattern.
//   out channel: one result per input transfer: recalled pattern, status, sweep count.
//   cfg port: apb-style writes of limit_enable (0x0), max_samples (0x4), max_sweeps (0x8),
//   to be written only while the block is idle, a rule on the user that the block does not enforce.
// sequencing
//   one item at a time. training reads and rewrites each weight row once through a
//   registered read; a rejected item skips this pass.
//   recall runs sweeps over all neurons, one neuron a cycle through the sum tree, until
//   a sweep changes no neuron or the sweep limit is reached.
// reset
//   synchronous; clears weights (per-row valid bits), sample count, neuron states and
//   config to defaults; no clearing pass, the block is ready as soon as reset ends.
// stalls
//   a finished result waits in the output register; the next item is taken meanwhile and
//   its result waits for the register to be free.
`default_nettype none

module hebbian_associative_recall import hbar_pkg::*; #(
  parameter int NEURONS     = NEURONS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  in_tdata,    // pattern[15:0]
  input  wire logic                      in_tuser,    // command[0]
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0]      out_tdata,   // result_pattern[15:0], status[17:16],
                                                      // sweeps_used[25:18], zero[31:26]
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]       cfg_prdata,
  output logic                           cfg_pready
);

  localparam int PAD_BITS = OUT_TDATA_BITS - PAT_BITS - STATUS_BITS - SWEEP_BITS;

  logic                      limit_enable_r;
  logic [CNT_BITS-1:0]       max_samples_r;
  logic [SWEEP_BITS-1:0]     max_sweeps_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_BITS-1:0] out_tdata_r;
  logic                      out_free;

  dp_cmd_t                   cmd;
  dp_stat_t                  stat;
  res_t                      res;
  logic [$clog2(NEURONS)-1:0] rd_addr;
  logic [PAT_BITS-1:0]       result_pattern;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_LIMIT_ENABLE: cfg_prdata = CFG_DATA_BITS'(limit_enable_r);
      REG_MAX_SAMPLES:  cfg_prdata = CFG_DATA_BITS'(max_samples_r);
      REG_MAX_SWEEPS:   cfg_prdata = CFG_DATA_BITS'(max_sweeps_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_enable_r <= LIMIT_ENABLE_RST;
      max_samples_r  <= MAX_SAMPLES_RST;
      max_sweeps_r   <= MAX_SWEEPS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIMIT_ENABLE: limit_enable_r <= cfg_pwdata[0];
        REG_MAX_SAMPLES:  max_samples_r  <= cfg_pwdata[CNT_BITS-1:0];
        REG_MAX_SWEEPS:   max_sweeps_r   <= cfg_pwdata[SWEEP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  hbar_ctrl #(
    .NEURONS (NEURONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tuser),
    .in_ready   (in_tready),
    .stat       (stat),
    .max_sweeps (max_sweeps_r),
    .out_free   (out_free),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .res        (res)
  );

  hbar_dp #(
    .NEURONS     (NEURONS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .pattern        (in_tdata[PAT_BITS-1:0]),
    .limit_enable   (limit_enable_r),
    .max_samples    (max_samples_r),
    .stat           (stat),
    .result_pattern (result_pattern)
  );

  // result register
  assign out_free = ~out_tvalid_r | out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res.load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_tdata_r <= {{PAD_BITS{1'b0}}, res.sweeps, res.status,
                      res.recall ? result_pattern : {PAT_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17:16] == STAT_REJECTED)
      |-> (out_tdata[25:18] == '0 && out_tdata[15:0] == '0))
    else $error("rejected training result carries data");

  a_noconv_swept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17:16] == STAT_NO_CONVERGE) |-> out_tdata[25:18] != '0)
    else $error("sweep limit status without any sweep");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while previous item still in work");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// ----- sv/hbar_dp.sv -----
// hbar_dp: weight row memory, hebbian row update, weighted sum tree and neuron states
// depends on hbar_pkg; driven by hbar_ctrl
`default_nettype none

module hbar_dp import hbar_pkg::*; #(
  parameter int NEURONS     = NEURONS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dp_cmd_t                      cmd,
  input  wire logic [$clog2(NEURONS)-1:0]   rd_addr,
  input  wire logic [PAT_BITS-1:0]          pattern,
  input  wire logic                         limit_enable,
  input  wire logic [CNT_BITS-1:0]          max_samples,
  output dp_stat_t                          stat,
  output logic [PAT_BITS-1:0]               result_pattern
);

  localparam int IDX_BITS = $clog2(NEURONS);
  localparam int ROW_BITS = NEURONS * WEIGHT_BITS;
  localparam int LVL      = $clog2(NEURONS);
  localparam int LEAVES   = 1 << LVL;
  localparam int SUM_BITS = WEIGHT_BITS + LVL + 1;
  localparam logic signed [WEIGHT_BITS:0] WMAX = (WEIGHT_BITS+1)'((1 << (WEIGHT_BITS-1)) - 1);

  logic [ROW_BITS-1:0] weight_mem [0:NEURONS-1];
  logic [NEURONS-1:0]  row_valid_r;
  logic [ROW_BITS-1:0] rd_row_r;
  logic                rd_ok_r;
  logic [IDX_BITS-1:0] rd_addr_r;
  logic [NEURONS-1:0]  bits_r, bits_nxt;
  logic                changed_r, changed_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  logic [ROW_BITS-1:0] row_eff;
  logic [ROW_BITS-1:0] row_new;
  logic [NEURONS-1:0]  pat_load;
  logic                wr_en;
  logic                eval;
  logic                new_bit;
  logic                diff;
  logic signed [SUM_BITS-1:0] node [0:2*LEAVES-2];

  assign row_eff = rd_ok_r ? rd_row_r : '0;
  assign wr_en   = cmd.upd_en & cmd.train;
  assign eval    = cmd.upd_en & ~cmd.train;

  // hebbian update of the row held in the read register
  for (genvar j = 0; j < NEURONS; j++) begin : g_lane
    logic signed [WEIGHT_BITS-1:0] w_old;
    logic signed [WEIGHT_BITS:0]   w_sum;
    logic [WEIGHT_BITS-1:0]        w_new;
    logic                          agree;
    assign w_old = row_eff[j*WEIGHT_BITS +: WEIGHT_BITS];
    assign agree = bits_r[rd_addr_r] == bits_r[j];
    assign w_sum = {w_old[WEIGHT_BITS-1], w_old}
                 + (agree ? (WEIGHT_BITS+1)'(1) : {(WEIGHT_BITS+1){1'b1}});
    always_comb begin
      if (rd_addr_r == IDX_BITS'(j)) begin
        w_new = '0;
      end else if (w_sum > WMAX) begin
        w_new = WMAX[WEIGHT_BITS-1:0];
      end else if (w_sum < -WMAX) begin
        w_new = WEIGHT_BITS'(-WMAX);
      end else begin
        w_new = w_sum[WEIGHT_BITS-1:0];
      end
    end
    assign row_new[j*WEIGHT_BITS +: WEIGHT_BITS] = w_new;
  end

  // signed weighted sum as a balanced adder tree
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < NEURONS) begin : g_used
      logic signed [SUM_BITS-1:0] w_ext;
      assign w_ext = SUM_BITS'($signed(row_eff[j*WEIGHT_BITS +: WEIGHT_BITS]));
      assign node[LEAVES-1+j] = bits_r[j] ? w_ext : -w_ext;
    end else begin : g_pad
      assign node[LEAVES-1+j] = '0;
    end
  end

  for (genvar k = 0; k < LEAVES-1; k++) begin : g_node
    assign node[k] = node[2*k+1] + node[2*k+2];
  end

  assign new_bit = ~node[0][SUM_BITS-1];
  assign diff    = new_bit != bits_r[rd_addr_r];

  always_comb begin
    for (int k = 0; k < NEURONS; k++) begin
      pat_load[k] = (k < PAT_BITS) ? pattern[k % PAT_BITS] : 1'b0;
    end
    for (int k = 0; k < PAT_BITS; k++) begin
      result_pattern[k] = (k < NEURONS) ? bits_r[k % NEURONS] : 1'b0;
    end
  end

  always_comb begin
    bits_nxt = bits_r;
    if (cmd.capture) begin
      bits_nxt = pat_load;
    end else if (eval) begin
      bits_nxt[rd_addr_r] = new_bit;
    end
  end

  always_comb begin
    changed_nxt = changed_r;
    if (cmd.sweep_start) begin
      changed_nxt = 1'b0;
    end else if (eval && diff) begin
      changed_nxt = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc && count_r != COUNT_MAX) begin
      count_nxt = count_r + CNT_BITS'(1);
    end
  end

  assign stat = '{reject:  limit_enable && (count_r >= max_samples),
                  changed: changed_r | (eval & diff)};

  // row memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[rd_addr_r] <= row_new;
    end
    if (cmd.rd_en) begin
      rd_row_r  <= weight_mem[rd_addr];
      rd_ok_r   <= row_valid_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      bits_r      <= '0;
      changed_r   <= 1'b0;
      count_r     <= '0;
    end else begin
      if (wr_en) begin
        row_valid_r[rd_addr_r] <= 1'b1;
      end
      bits_r    <= bits_nxt;
      changed_r <= changed_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hbar_ctrl.sv -----
// hbar_ctrl: sequencer for training passes and recall sweeps over the weight rows
// depends on hbar_pkg; commands hbar_dp
`default_nettype none

module hbar_ctrl import hbar_pkg::*; #(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_command,
  output logic                             in_ready,
  input  wire dp_stat_t                    stat,
  input  wire logic [SWEEP_BITS-1:0]       max_sweeps,
  input  wire logic                        out_free,
  output dp_cmd_t                          cmd,
  output logic [$clog2(NEURONS)-1:0]       rd_addr,
  output res_t                             res
);

  localparam int IDX_BITS  = $clog2(NEURONS);
  localparam int IDXC_BITS = $clog2(NEURONS + 1);
  localparam logic [IDXC_BITS-1:0] IDX_LAST = IDXC_BITS'(NEURONS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TRAIN  = 2'd1;
  localparam logic [1:0] S_RECALL = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [IDXC_BITS-1:0]   idx_r, idx_nxt;
  logic [SWEEP_BITS-1:0]  sweeps_r, sweeps_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic                   recall_r, recall_nxt;
  logic [SWEEP_BITS-1:0]  limit;
  logic [SWEEP_BITS-1:0]  sweeps_inc;

  assign limit      = (max_sweeps == '0) ? SWEEP_BITS'(1) : max_sweeps;
  assign sweeps_inc = sweeps_r + SWEEP_BITS'(1);
  assign rd_addr    = idx_r[IDX_BITS-1:0];
  assign in_ready   = state_r == S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    sweeps_nxt = sweeps_r;
    status_nxt = status_r;
    recall_nxt = recall_r;
    cmd        = '0;
    res.load   = 1'b0;
    res.recall = recall_r;
    res.status = status_r;
    res.sweeps = sweeps_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          recall_nxt  = in_command;
          idx_nxt     = '0;
          sweeps_nxt  = '0;
          status_nxt  = STAT_DONE;
          if (in_command == CMD_RECALL) begin
            state_nxt = S_RECALL;
          end else if (stat.reject) begin
            status_nxt = STAT_REJECTED;
            state_nxt  = S_FINISH;
          end else begin
            cmd.count_inc = 1'b1;
            state_nxt     = S_TRAIN;
          end
        end
      end
      S_TRAIN: begin
        cmd.train  = 1'b1;
        cmd.rd_en  = idx_r != IDX_LAST;
        cmd.upd_en = idx_r != '0;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + IDXC_BITS'(1);
        end
      end
      S_RECALL: begin
        cmd.rd_en       = idx_r != IDX_LAST;
        cmd.upd_en      = idx_r != '0;
        cmd.sweep_start = idx_r == '0;
        if (idx_r == IDX_LAST) begin
          sweeps_nxt = sweeps_inc;
          idx_nxt    = '0;
          if (!stat.changed || sweeps_inc == limit) begin
            status_nxt = stat.changed ? STAT_NO_CONVERGE : STAT_DONE;
            state_nxt  = S_FINISH;
          end
        end else begin
          idx_nxt = idx_r + IDXC_BITS'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          res.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      sweeps_r <= '0;
      status_r <= STAT_DONE;
      recall_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      sweeps_r <= sweeps_nxt;
      status_r <= status_nxt;
      recall_r <= recall_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- dv/hebbian_associative_recall_tb.sv -----
// hebbian_associative_recall_tb: self-checking testbench for the associative recall block
// a directed table, then randomized train/recall sequences checked against a hopfield predictor
// depends on hbar_pkg and hebbian_associative_recall
`default_nettype none

module hebbian_associative_recall_tb;
  import hbar_pkg::*;

  localparam int N         = NEURONS_DEF;
  localparam int WMAX      = (1 << (WEIGHT_BITS_DEF - 1)) - 1;
  localparam int RAND_ITEMS     = 1830;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PAT_BITS-1:0]    pattern;
    logic [STATUS_BITS-1:0] status;
    logic [SWEEP_BITS-1:0]  sweeps;
  } recall_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [1:0]     reg_idx;
    logic [15:0]    value;    // pattern, or register data
    logic           cmd;
    recall_result_t want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;   // pattern[15:0]
  logic                      in_tuser = 1'b0; // command[0]
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;       // result_pattern[15:0], status[17:16],
                                              // sweeps_used[25:18], zero[31:26]
  logic                      cfg_psel = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_prdata;
  logic                      cfg_pready;

  // predictor state
  int                    weights [N][N];
  logic [PAT_BITS-1:0]   neuron_state = '0;
  int                    stored_n = 0;
  logic                  lim_en = LIMIT_ENABLE_RST;
  logic [CNT_BITS-1:0]   max_samp = MAX_SAMPLES_RST;
  logic [SWEEP_BITS-1:0] max_sw = MAX_SWEEPS_RST;

  recall_result_t pending_results [$];
  recall_result_t head_result;
  stim_row_t      stim_rows [$];
  int             mismatches = 0;
  int             results_seen = 0;
  logic           no_idle = 1'b0;

  hebbian_associative_recall u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic recall_result_t hopfield_step(input logic cmd,
                                                   input logic [PAT_BITS-1:0] pat);
    recall_result_t r;
    int             sweep_cap;
    int             n;
    int             sum;
    logic           changed;
    r = '0;
    if (cmd == CMD_TRAIN) begin
      if (lim_en && stored_n >= int'(max_samp)) begin
        r.status = STAT_REJECTED;
      end else begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N; j++) begin
            if (i == j) begin
              weights[i][j] = 0;
            end else begin
              sum = weights[i][j] + ((pat[i] == pat[j]) ? 1 : -1);
              weights[i][j] = (sum > WMAX) ? WMAX : (sum < -WMAX) ? -WMAX : sum;
            end
          end
        end
        if (stored_n < int'(COUNT_MAX)) stored_n++;
        r.status = STAT_DONE;
      end
    end else begin
      sweep_cap = (max_sw == 0) ? 1 : int'(max_sw);
      neuron_state = pat;
      n = 0;
      changed = 1'b1;
      while (changed && n < sweep_cap) begin
        changed = 1'b0;
        for (int i = 0; i < N; i++) begin
          sum = 0;
          for (int j = 0; j < N; j++) begin
            sum += neuron_state[j] ? weights[i][j] : -weights[i][j];
          end
          if ((sum >= 0) != neuron_state[i]) begin
            changed = 1'b1;
            neuron_state[i] = ~neuron_state[i];
          end
        end
        n++;
      end
      r.pattern = neuron_state;
      r.status  = changed ? STAT_NO_CONVERGE : STAT_DONE;
      r.sweeps  = n[SWEEP_BITS-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 50) begin
      $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_item(input logic cmd, input logic [PAT_BITS-1:0] pat,
                           input logic fixed, input recall_result_t fixed_want);
    recall_result_t predicted;
    while (!no_idle && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= pat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = hopfield_step(cmd, pat);
    pending_results.push_back(fixed ? fixed_want : predicted);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BITS'(idx) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LIMIT_ENABLE: lim_en   = value[0];
      REG_MAX_SAMPLES:  max_samp = value[CNT_BITS-1:0];
      REG_MAX_SWEEPS:   max_sw   = value[SWEEP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transfer with nothing pending", out_tdata, 0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_tdata[15:0] != head_result.pattern)
          report_mismatch("result_pattern", out_tdata[15:0], head_result.pattern);
        if (out_tdata[17:16] != head_result.status)
          report_mismatch("status", out_tdata[17:16], head_result.status);
        if (out_tdata[25:18] != head_result.sweeps)
          report_mismatch("sweeps_used", out_tdata[25:18], head_result.sweeps);
        if (out_tdata[31:26] != '0)
          report_mismatch("padding", out_tdata[31:26], 0);
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no transfer on any port
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [PAT_BITS-1:0] bases [4];
    logic [PAT_BITS-1:0] noise;
    logic [PAT_BITS-1:0] pat;
    int                  n_bases;
    int                  phase_len;
    int                  phase;
    int                  sent;
    int                  pick;
    logic [31:0]         v;

    // kind, reg index, pattern or data, command, expected {pattern, status, sweeps}
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'h0000, CMD_RECALL, '{16'hFFFF, STAT_DONE, 8'd2}});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'hFFFF, CMD_RECALL, '{16'hFFFF, STAT_DONE, 8'd1}});
    // zero sweep limit acts as one
    stim_rows.push_back('{ROW_REG, REG_MAX_SWEEPS, 16'd0, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'h0000, CMD_RECALL,
                          '{16'hFFFF, STAT_NO_CONVERGE, 8'd1}});
    stim_rows.push_back('{ROW_REG, REG_MAX_SWEEPS, 16'd255, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_REG, REG_LIMIT_ENABLE, 16'd1, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_REG, REG_MAX_SAMPLES, 16'd0, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'h1234, CMD_TRAIN, '{16'h0, STAT_REJECTED, 8'd0}});
    stim_rows.push_back('{ROW_REG, REG_MAX_SAMPLES, 16'd2, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'hA5A5, CMD_TRAIN, '{16'h0, STAT_DONE, 8'd0}});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'h0F0F, CMD_TRAIN, '{16'h0, STAT_DONE, 8'd0}});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'hFFFF, CMD_TRAIN, '{16'h0, STAT_REJECTED, 8'd0}});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'hA5A5, CMD_RECALL, '0});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'hA5A4, CMD_RECALL, '0});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'h5A5A, CMD_RECALL, '0});
    // write to an unmapped register must not disturb anything
    stim_rows.push_back('{ROW_REG, REG_UNUSED, 16'h00FF, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_REG, REG_LIMIT_ENABLE, 16'd0, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'hFFFF, CMD_TRAIN, '{16'h0, STAT_DONE, 8'd0}});
    stim_rows.push_back('{ROW_CHECKED, 2'd0, 16'h0000, CMD_TRAIN, '{16'h0, STAT_DONE, 8'd0}});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'h8001, CMD_RECALL, '0});
    stim_rows.push_back('{ROW_REG, REG_MAX_SWEEPS, 16'd1, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'h1234, CMD_RECALL, '0});
    stim_rows.push_back('{ROW_REG, REG_MAX_SAMPLES, 16'd64, CMD_TRAIN, '0});
    stim_rows.push_back('{ROW_ITEM, 2'd0, 16'hFFFF, CMD_RECALL, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      case (stim_rows[k].kind)
        ROW_REG: begin
          drain();
          write_reg(stim_rows[k].reg_idx, 32'(stim_rows[k].value));
        end
        ROW_CHECKED: send_item(stim_rows[k].cmd, stim_rows[k].value, 1'b1, stim_rows[k].want);
        default:     send_item(stim_rows[k].cmd, stim_rows[k].value, 1'b0, '0);
      endcase
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      no_idle = (phase == 3 || phase == 4);
      write_reg(REG_LIMIT_ENABLE, ($urandom_range(99) < 30) ? 32'd1 : 32'd0);
      case ($urandom_range(3))
        0:       v = 32'd0;
        1:       v = 32'd64;
        default: v = $urandom_range(64);
      endcase
      write_reg(REG_MAX_SAMPLES, v);
      case ($urandom_range(3))
        0:       v = 32'd1;
        1:       v = 32'd255;
        2:       v = 32'd2;
        default: v = $urandom_range(255, 1);
      endcase
      write_reg(REG_MAX_SWEEPS, v);

      n_bases = $urandom_range(4, 2);
      for (int b = 0; b < 4; b++) bases[b] = PAT_BITS'($urandom);
      phase_len = $urandom_range(200, 120);
      for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        pick = $urandom_range(99);
        noise = '0;
        if (pick < 30) begin
          if ($urandom_range(4) == 0) noise[$urandom_range(15)] = 1'b1;
          send_item(CMD_TRAIN, bases[$urandom_range(n_bases - 1)] ^ noise, 1'b0, '0);
        end else if (pick < 80) begin
          repeat ($urandom_range(4)) noise[$urandom_range(15)] = 1'b1;
          send_item(CMD_RECALL, bases[$urandom_range(n_bases - 1)] ^ noise, 1'b0, '0);
        end else begin
          pat = PAT_BITS'($urandom);
          send_item(($urandom_range(1) == 0) ? CMD_TRAIN : CMD_RECALL, pat, 1'b0, '0);
        end
        sent++;
      end
      phase++;
    end

    drain();
    no_idle = 1'b0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/hbar_pkg.sv
sv/hbar_dp.sv
sv/hbar_ctrl.sv
sv/hebbian_associative_recall.sv
dv/hebbian_associative_recall_tb.sv
